### design/snuv_pkg.sv
// Shared types, constants and the arctangent table for sphere_normal_to_uv_core.
// No dependencies.
package snuv_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    // Iterations actually built: the table bounds the count.
    localparam int NUM_ITER = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int IDX_W    = $clog2(ATAN_ENTRIES);

    localparam int COMP_W  = 16;              // input component width
    localparam int ROT_W   = 33;              // CORDIC x/y datapath width
    localparam int ANGLE_W = 32;              // angle as a fraction of a full turn
    localparam int U_W     = 16;
    localparam int V_W     = 17;

    localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
    localparam logic [ANGLE_W-1:0] U_ROUND = 32'h0000_8000;

    localparam logic [V_W-1:0] V_FULL = 17'h1_0000;

    typedef struct packed {
        logic signed [ROT_W-1:0] cx;
        logic signed [ROT_W-1:0] cy;
        logic [ANGLE_W-1:0]      acc;
        logic                    z_zero;
        logic                    x_zero;
        logic                    x_neg;
        logic                    z_pos;
        logic [V_W-1:0]          tex_v;
    } stage_t;

    // atan(2^-i) / (2pi) * 2^32, rounded to nearest
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] r;
        case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051E;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2FA;
            5'd15:   r = 32'h0000_517D;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A30;
            5'd19:   r = 32'h0000_0518;
            5'd20:   r = 32'h0000_028C;
            5'd21:   r = 32'h0000_0146;
            5'd22:   r = 32'h0000_00A3;
            5'd23:   r = 32'h0000_0051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### design/sphere_normal_to_uv_core.sv
// Spherical texture coordinates (u, v) from a unit normal, pipelined CORDIC.
// Depends on snuv_pkg.
//
// Takes one normal (Q2.14 x, y, z) per clock and returns tex_u (azimuth as a
// fraction of a full turn, Q0.16) and tex_v = (1 - y) / 2 (Q1.16, saturated).
// Pipeline: one input stage, one register stage per CORDIC iteration, and
// the output register. Every stage holds a valid bit and only stalls when
// the stage after it is full, so bubbles close up and a new request is
// taken each cycle while out_ready is high; throughput is one item per
// clock.
module sphere_normal_to_uv_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [snuv_pkg::COMP_W-1:0] normal_x,
    input  logic signed [snuv_pkg::COMP_W-1:0] normal_y,
    input  logic signed [snuv_pkg::COMP_W-1:0] normal_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [snuv_pkg::U_W-1:0]          tex_u,
    output logic [snuv_pkg::V_W-1:0]          tex_v
);
    import snuv_pkg::*;

    stage_t stage_reg [0:NUM_ITER];
    stage_t stage_next [0:NUM_ITER];
    logic [NUM_ITER:0] valid_reg;
    logic [NUM_ITER:0] stage_rdy;

    logic              out_valid_reg;
    logic [U_W-1:0]    tex_u_reg;
    logic [U_W-1:0]    tex_u_next;
    logic [V_W-1:0]    tex_v_reg;
    logic              out_load;

    // ---------------- handshake chain ----------------
    assign out_load = !out_valid_reg || out_ready;
    assign stage_rdy[NUM_ITER] = !valid_reg[NUM_ITER] || out_load;

    genvar k;
    generate
        for (k = 0; k < NUM_ITER; k++) begin : g_rdy
            assign stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    endgenerate

    assign in_ready = stage_rdy[0];

    // ---------------- input stage ----------------
    logic [COMP_W:0]        abs_x;
    logic [COMP_W:0]        abs_z;
    logic signed [COMP_W+1:0] v_diff;

    always_comb
    begin
        abs_x = normal_x[COMP_W-1] ? (COMP_W+1)'(-$signed({normal_x[COMP_W-1], normal_x}))
                                   : {1'b0, normal_x};
        abs_z = normal_z[COMP_W-1] ? (COMP_W+1)'(-$signed({normal_z[COMP_W-1], normal_z}))
                                   : {1'b0, normal_z};
        v_diff = 18'sd16384 - {{2{normal_y[COMP_W-1]}}, normal_y};

        stage_next[0].cx     = $signed({2'b00, abs_z, 14'b0});
        stage_next[0].cy     = $signed({2'b00, abs_x, 14'b0});
        stage_next[0].acc    = '0;
        stage_next[0].z_zero = (normal_z == '0);
        stage_next[0].x_zero = (normal_x == '0);
        stage_next[0].x_neg  = normal_x[COMP_W-1];
        stage_next[0].z_pos  = !normal_z[COMP_W-1] && (normal_z != '0);
        if (v_diff[COMP_W+1])
            stage_next[0].tex_v = '0;
        else if (v_diff > 18'sd32768)
            stage_next[0].tex_v = V_FULL;
        else
            stage_next[0].tex_v = {v_diff[15:0], 1'b0};
    end

    // ---------------- CORDIC vectoring stages ----------------
    generate
        for (k = 0; k < NUM_ITER; k++) begin : g_iter
            logic signed [ROT_W-1:0] cx_cur;
            logic signed [ROT_W-1:0] cy_cur;
            logic signed [ROT_W-1:0] dx;
            logic signed [ROT_W-1:0] dy;
            logic [ANGLE_W-1:0]      step;

            assign cx_cur = stage_reg[k].cx;
            assign cy_cur = stage_reg[k].cy;
            assign dx     = cy_cur >>> k;
            assign dy     = cx_cur >>> k;
            assign step   = atan_turn(IDX_W'(k));

            always_comb
            begin
                stage_next[k+1] = stage_reg[k];
                if (!cy_cur[ROT_W-1])
                begin
                    stage_next[k+1].cx  = cx_cur + dx;
                    stage_next[k+1].cy  = cy_cur - dy;
                    stage_next[k+1].acc = stage_reg[k].acc + step;
                end
                else
                begin
                    stage_next[k+1].cx  = cx_cur - dx;
                    stage_next[k+1].cy  = cy_cur + dy;
                    stage_next[k+1].acc = stage_reg[k].acc - step;
                end
            end
        end
    endgenerate

    // ---------------- stage registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (stage_rdy[0])
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0] && in_valid)
            stage_reg[0] <= stage_next[0];
    end

    generate
        for (k = 1; k <= NUM_ITER; k++) begin : g_regs
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (stage_rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (stage_rdy[k] && valid_reg[k-1])
                    stage_reg[k] <= stage_next[k];
            end
        end
    endgenerate

    // ---------------- quadrant fold and rounding ----------------
    logic [ANGLE_W-1:0] theta;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] angle_rnd;

    always_comb
    begin
        theta = stage_reg[NUM_ITER].x_zero ? '0 : stage_reg[NUM_ITER].acc;
        if (stage_reg[NUM_ITER].z_zero)
        begin
            if (stage_reg[NUM_ITER].x_zero)
                angle = HALF_TURN;
            else if (stage_reg[NUM_ITER].x_neg)
                angle = THREE_QUARTER_TURN;
            else
                angle = QUARTER_TURN;
        end
        else if (!stage_reg[NUM_ITER].x_neg)
            angle = stage_reg[NUM_ITER].z_pos ? theta : HALF_TURN - theta;
        else
            angle = stage_reg[NUM_ITER].z_pos ? HALF_TURN + theta : ANGLE_W'(0) - theta;
        angle_rnd  = angle + U_ROUND;
        tex_u_next = angle_rnd[ANGLE_W-1:ANGLE_W-U_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= valid_reg[NUM_ITER];
    end

    always_ff @(posedge clk)
    begin
        if (out_load && valid_reg[NUM_ITER])
        begin
            tex_u_reg <= tex_u_next;
            tex_v_reg <= stage_reg[NUM_ITER].tex_v;
        end
    end

    assign out_valid = out_valid_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;

`ifndef NO_ASSERTIONS
    // Backpressure reaches the input only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && out_valid_reg)
        else $error("input stalled with a bubble in the pipeline");

    // The CORDIC magnitude stays positive through the last stage.
    a_cx_pos: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_ITER] && !stage_reg[NUM_ITER].z_zero |-> !stage_reg[NUM_ITER].cx[ROT_W-1])
        else $error("CORDIC x went negative");

    // A request entering stage 0 shows up in stage 1 when stage 1 advances.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && stage_rdy[1] |=> valid_reg[1])
        else $error("item lost between stage 0 and stage 1");

    // A stalled result is not overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(tex_u_reg) && $stable(tex_v_reg))
        else $error("stalled result changed");

    a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> tex_v_reg <= V_FULL)
        else $error("tex_v out of range");
`endif

endmodule
